// ----- src/sfwe_pkg.sv -----
`timescale 1ns / 1ps

package sfwe_pkg;

   // Each vertex takes four command words; s and t sit at positions two and three.
   localparam int WORDS_PER_VERTEX = 4;
   localparam logic [1:0] PHASE_S = 2'd2;
   localparam logic [1:0] PHASE_T = 2'(WORDS_PER_VERTEX - 1);

   // Coordinates carry eight fraction bits; the reset scale is one in Q8.8.
   localparam int FRAC_BITS = 8;
   localparam logic [15:0] SCALE_RESET = 16'(1 << FRAC_BITS);

   // Largest vertex count that the 15-bit counter holds.
   localparam logic [14:0] MAX_LEFT = 15'h7fff;

   // Number of vertices held so far in the open primitive.
   typedef enum logic [1:0] {
      SEEN_NONE,
      SEEN_ONE,
      SEEN_TWO
   } seen_type;

   // One raw segment: end points as {t, s}, unscaled.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        last;
   } seg_type;

   // Head of the pending segment buffer as seen by the output stage.
   typedef struct packed {
      logic    valid;
      seg_type seg;
   } head_type;

endpackage

// ----- src/sfwe_ingest.sv -----
`timescale 1ns / 1ps

module sfwe_ingest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_cmd_word,
   output sfwe_pkg::head_type  head,
   input  logic                out_free
);

   // Primitive decode state.
   logic [14:0]        left_ff, left_in;
   logic               fan_ff, fan_in;
   logic [1:0]         phase_ff, phase_in;
   sfwe_pkg::seen_type seen_ff, seen_in;
   logic [15:0]        pend_s_ff, pend_s_in;
   logic [31:0]        first_ff, first_in;
   logic [31:0]        second_ff, second_in;

   // Pending segments of the last word, at most two.
   logic [1:0]         cnt_ff, cnt_in;
   sfwe_pkg::seg_type  seg0_ff, seg0_in;
   sfwe_pkg::seg_type  seg1_ff, seg1_in;

   logic               accept;
   logic               take;
   logic [15:0]        w;
   logic [15:0]        mag;
   logic [31:0]        v;
   logic [14:0]        left_dec;
   logic [1:0]         new_cnt;
   sfwe_pkg::seg_type  new0;
   sfwe_pkg::seg_type  new1;

   // A word is taken when the buffer is empty or drains this cycle.
   assign take      = (cnt_ff != 2'd0) && out_free;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && out_free));
   assign accept    = req_valid && !req_stall;

   assign head.valid = (cnt_ff != 2'd0);
   assign head.seg   = seg0_ff;

   // Decode of the word and next primitive state.
   always_comb begin
      w         = req_cmd_word;
      mag       = ~w + 16'd1;
      v         = {w, pend_s_ff};
      left_dec  = left_ff - 15'd1;
      left_in   = left_ff;
      fan_in    = fan_ff;
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      pend_s_in = pend_s_ff;
      first_in  = first_ff;
      second_in = second_ff;
      new_cnt   = 2'd0;
      new0      = '{a: second_ff, b: v, last: 1'b0};
      new1      = '{a: first_ff, b: v, last: 1'b1};
      if (accept) begin
         if (left_ff == 15'd0) begin
            if (w != 16'd0) begin
               if (w[15]) begin
                  left_in = mag[15] ? sfwe_pkg::MAX_LEFT : mag[14:0];
                  fan_in  = 1'b1;
               end else begin
                  left_in = w[14:0];
                  fan_in  = 1'b0;
               end
               phase_in = 2'd0;
               seen_in  = sfwe_pkg::SEEN_NONE;
            end
         end else if (phase_ff != sfwe_pkg::PHASE_T) begin
            if (phase_ff == sfwe_pkg::PHASE_S) begin
               pend_s_in = w;
            end
            phase_in = phase_ff + 2'd1;
         end else begin
            // The t word completes a vertex.
            phase_in = 2'd0;
            unique case (seen_ff)
               sfwe_pkg::SEEN_NONE: begin
                  first_in = v;
                  seen_in  = sfwe_pkg::SEEN_ONE;
               end
               sfwe_pkg::SEEN_ONE: begin
                  new_cnt   = 2'd1;
                  new0      = '{a: first_ff, b: v, last: 1'b1};
                  second_in = v;
                  seen_in   = sfwe_pkg::SEEN_TWO;
               end
               default: begin
                  new_cnt   = 2'd2;
                  second_in = v;
                  if (!fan_ff) begin
                     new1     = '{a: v, b: first_ff, last: 1'b1};
                     first_in = second_ff;
                  end
               end
            endcase
            left_in = left_dec;
            if (left_dec == 15'd0) begin
               seen_in = sfwe_pkg::SEEN_NONE;
            end
         end
      end
   end

   // Segment buffer: load a new word's segments or shift after a take.
   always_comb begin
      cnt_in  = cnt_ff;
      seg0_in = seg0_ff;
      seg1_in = seg1_ff;
      if (accept) begin
         cnt_in  = new_cnt;
         seg0_in = new0;
         seg1_in = new1;
      end else if (take) begin
         cnt_in  = cnt_ff - 2'd1;
         seg0_in = seg1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         fan_ff   <= 1'b0;
         phase_ff <= '0;
         seen_ff  <= sfwe_pkg::SEEN_NONE;
         cnt_ff   <= '0;
      end else begin
         left_ff  <= left_in;
         fan_ff   <= fan_in;
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_s_ff <= pend_s_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      seg0_ff   <= seg0_in;
      seg1_ff   <= seg1_in;
   end

endmodule

// ----- src/sfwe_emit.sv -----
`timescale 1ns / 1ps

module sfwe_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  sfwe_pkg::head_type  head,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_start_x,
   output logic signed [31:0]  rsp_start_y,
   output logic signed [31:0]  rsp_end_x,
   output logic signed [31:0]  rsp_end_y,
   output logic                rsp_last_segment
);

   logic [15:0]        scale_ff;
   logic               valid_ff, valid_in;
   logic signed [31:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic               last_ff;
   logic signed [32:0] p_sx, p_sy, p_ex, p_ey;
   logic signed [16:0] scale_s;

   // Scale register, Q8.8 unsigned.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= sfwe_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // Four signed by unsigned products; each fits in 32 bits.
   assign scale_s = $signed({1'b0, scale_ff});
   assign p_sx = $signed(head.seg.a[15:0])  * scale_s;
   assign p_sy = $signed(head.seg.a[31:16]) * scale_s;
   assign p_ex = $signed(head.seg.b[15:0])  * scale_s;
   assign p_ey = $signed(head.seg.b[31:16]) * scale_s;

   // The output register takes a new word when empty or when its word leaves.
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && head.valid) begin
         sx_ff   <= p_sx[31:0];
         sy_ff   <= p_sy[31:0];
         ex_ff   <= p_ex[31:0];
         ey_ff   <= p_ey[31:0];
         last_ff <= head.seg.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_start_x      = sx_ff;
   assign rsp_start_y      = sy_ff;
   assign rsp_end_x        = ex_ff;
   assign rsp_end_y        = ey_ff;
   assign rsp_last_segment = last_ff;

endmodule

// ----- src/strip_fan_wireframe_edge_gen.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  cmd_word, signed 16 bits
// rsp_      out        rsp_valid/rsp_stall  start_x/y, end_x/y (32 bits), last_segment
// csr_      in         csr_wr_en            coord_scale, unsigned Q8.8
//
// A command word that yields no segment or one segment is taken every cycle while
// rsp_stall is low; a word with two segments holds off the next word until its
// first has moved on, set by the single output port. The first segment of a word
// passes the segment buffer, then the scale multipliers into the output register.
// Reset is synchronous; the scale returns to one and no primitive is open.
// While rsp_stall is high the output word holds and req_stall rises as soon as a
// segment waits in the segment buffer.

module strip_fan_wireframe_edge_gen (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_cmd_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_start_x,
   output logic signed [31:0]  rsp_start_y,
   output logic signed [31:0]  rsp_end_x,
   output logic signed [31:0]  rsp_end_y,
   output logic                rsp_last_segment,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   sfwe_pkg::head_type head;
   logic               out_free;

   // Command decode and segment buffer.
   sfwe_ingest u_ingest (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd_word (req_cmd_word),
      .head         (head),
      .out_free     (out_free)
   );

   // Scaling and output register.
   sfwe_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head             (head),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

// ----- bench/tb_strip_fan_wireframe_edge_gen.sv -----
`timescale 1ns / 1ps

module tb_strip_fan_wireframe_edge_gen;

   localparam int RESET_CYCLES = 10;
   localparam int IDLE_PCT     = 23;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;
   localparam int WATCH_LIMIT  = 3000;
   localparam int PHASE_WORDS  = 255;
   localparam int NUM_PHASES   = 6;
   localparam int SAT_VERTS    = 10;
   localparam int SHOWN_ERRORS = 10;

   // One scaled line segment as it leaves the block.
   typedef struct packed {
      logic [31:0] start_x;
      logic [31:0] start_y;
      logic [31:0] end_x;
      logic [31:0] end_y;
      logic        last_seg;
   } seg_out_type;

   // One row of the directed table; typed rows carry their own expectation.
   typedef struct packed {
      logic [15:0] word;
      logic        typed;
      logic        one_seg;
      seg_out_type seg;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_cmd_word = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_start_x;
   logic [31:0] rsp_start_y;
   logic [31:0] rsp_end_x;
   logic [31:0] rsp_end_y;
   logic        rsp_last_segment;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   strip_fan_wireframe_edge_gen i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd_word     (req_cmd_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_last_segment (rsp_last_segment),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Predictor state: the open primitive and its held raw vertices as {t, s}.
   logic [15:0]        pr_scale;
   logic [14:0]        pr_left;
   logic               pr_fan;
   logic [1:0]         pr_pos;
   sfwe_pkg::seen_type pr_seen;
   logic [15:0]        pr_s;
   logic [31:0]        pr_first;
   logic [31:0]        pr_second;
   seg_out_type        step_segs [2];

   seg_out_type segs_due [$];
   dir_row_type dir_rows [$];

   int          gen_left;
   int          gen_pos;
   bit          calm;
   int          hold_asks;
   int          holds_done;
   int          hold_cnt;
   int          mismatches;
   int          words_sent;
   int          segs_checked;
   int          quiet_cycles;

   // Signed 16-bit coordinate times the unsigned Q8.8 scale; the product is exact.
   function automatic logic [31:0] scaled(input logic [15:0] raw);
      return 32'(int'($signed(raw)) * int'({16'h0000, pr_scale}));
   endfunction

   function automatic seg_out_type make_seg(input logic [31:0] a, input logic [31:0] b,
                                            input logic last);
      seg_out_type s;
      s.start_x  = scaled(a[15:0]);
      s.start_y  = scaled(a[31:16]);
      s.end_x    = scaled(b[15:0]);
      s.end_y    = scaled(b[31:16]);
      s.last_seg = last;
      return s;
   endfunction

   // Advances the predictor by one command word; the segments land in step_segs.
   function automatic int edge_step(input logic [15:0] w);
      logic [15:0] mag;
      logic [31:0] v;
      int          n;
      n = 0;
      // With no primitive open the word is a count.
      if (pr_left == 15'd0) begin
         if (w == 16'h0000)
            return 0;
         if (w[15]) begin
            mag = 16'h0000 - w;
            pr_left = (mag > {1'b0, sfwe_pkg::MAX_LEFT}) ? sfwe_pkg::MAX_LEFT : mag[14:0];
            pr_fan = 1'b1;
         end else begin
            pr_left = w[14:0];
            pr_fan = 1'b0;
         end
         pr_pos = 2'd0;
         pr_seen = sfwe_pkg::SEEN_NONE;
         return 0;
      end
      if (pr_pos == sfwe_pkg::PHASE_S)
         pr_s = w;
      if (pr_pos != sfwe_pkg::PHASE_T) begin
         pr_pos = pr_pos + 2'd1;
         return 0;
      end
      // The t word completes the vertex.
      pr_pos = 2'd0;
      v = {w, pr_s};
      case (pr_seen)
         sfwe_pkg::SEEN_NONE: begin
            pr_first = v;
            pr_seen = sfwe_pkg::SEEN_ONE;
         end
         sfwe_pkg::SEEN_ONE: begin
            step_segs[0] = make_seg(pr_first, v, 1'b1);
            n = 1;
            pr_second = v;
            pr_seen = sfwe_pkg::SEEN_TWO;
         end
         default: begin
            step_segs[0] = make_seg(pr_second, v, 1'b0);
            if (pr_fan) begin
               step_segs[1] = make_seg(pr_first, v, 1'b1);
            end else begin
               step_segs[1] = make_seg(v, pr_first, 1'b1);
               pr_first = pr_second;
            end
            pr_second = v;
            n = 2;
         end
      endcase
      pr_left = pr_left - 15'd1;
      if (pr_left == 15'd0)
         pr_seen = sfwe_pkg::SEEN_NONE;
      return n;
   endfunction

   // Random command stream: mostly well-formed strips and fans of random size and content.
   function automatic logic [15:0] next_cmd_word();
      logic [15:0] w;
      int          mag;
      if (gen_left == 0) begin
         if ($urandom_range(99) < 6)
            return 16'h0000;
         mag = ($urandom_range(99) < 75) ? $urandom_range(5, 1) : $urandom_range(30, 6);
         gen_left = mag;
         gen_pos = 0;
         w = 16'(mag);
         return $urandom_range(1) ? w : 16'h0000 - w;
      end
      if (gen_pos >= 2 && $urandom_range(99) < 15) begin
         case ($urandom_range(3))
            0: w = 16'h7FFF;
            1: w = 16'h8000;
            2: w = 16'h0000;
            default: w = 16'hFFFF;
         endcase
      end else begin
         w = 16'($urandom);
      end
      if (gen_pos == 3) begin
         gen_pos = 0;
         gen_left = gen_left - 1;
      end else begin
         gen_pos = gen_pos + 1;
      end
      return w;
   endfunction

   function automatic void add_row(input logic [15:0] w, input logic typed,
                                   input logic one_seg, input seg_out_type seg);
      dir_row_type r;
      r.word = w;
      r.typed = typed;
      r.one_seg = one_seg;
      r.seg = seg;
      dir_rows.push_back(r);
   endfunction

   function automatic void queue_step(input logic [15:0] w);
      int n;
      n = edge_step(w);
      for (int i = 0; i < n; i++)
         segs_due.push_back(step_segs[i]);
   endfunction

   // Offers one word, with random idle cycles first, and returns at the accepting edge.
   task automatic send_word(input logic [15:0] w);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd_word <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
   endtask

   // Lets every expected segment arrive, then waits the SETTLE period with no request offered.
   task automatic settle();
      req_valid <= 1'b0;
      while (segs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_scale(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pr_scale = v;
   endtask

   task automatic report(input string what, input seg_out_type want, input seg_out_type got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("%0t %s: expected %h %h %h %h %b, got %h %h %h %h %b", $time, what,
                  want.start_x, want.start_y, want.end_x, want.end_y, want.last_seg,
                  got.start_x, got.start_y, got.end_x, got.end_y, got.last_seg);
   endtask

   // Result checker: each accepted segment against the oldest expectation.
   always @(posedge clock) begin
      seg_out_type got;
      seg_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y, rsp_last_segment};
         if (segs_due.size() == 0) begin
            report("unexpected segment", got, got);
         end else begin
            want = segs_due.pop_front();
            segs_checked++;
            if (got !== want)
               report("segment mismatch", want, got);
         end
      end
   end

   // Receiver: random stalls, a calm stretch, and long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt != 0) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt - 1;
      end else if (holds_done != hold_asks) begin
         holds_done <= holds_done + 1;
         hold_cnt <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCH_LIMIT) begin
         $display("timeout after %0d quiet cycles", WATCH_LIMIT);
         $display("tb_strip_fan_wireframe_edge_gen: done, errors");
         $finish;
      end
   end

   initial begin
      int          n;
      logic [15:0] w;
      logic [15:0] phase_scale;
      gen_left = 0;
      gen_pos = 0;
      calm = 1'b0;
      hold_asks = 0;
      holds_done = 0;
      hold_cnt = 0;
      mismatches = 0;
      words_sent = 0;
      segs_checked = 0;
      quiet_cycles = 0;
      pr_scale = sfwe_pkg::SCALE_RESET;
      pr_left = '0;
      pr_fan = 1'b0;
      pr_pos = 2'd0;
      pr_seen = sfwe_pkg::SEEN_NONE;
      pr_s = '0;
      pr_first = '0;
      pr_second = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_scale(sfwe_pkg::SCALE_RESET);

      // Directed words at unit scale: zero count, a two-vertex strip at the coordinate
      // extremes, a fan of one vertex, then a three-vertex fan.
      add_row(16'h0000, 1'b1, 1'b0, '0);
      add_row(16'h0002, 1'b1, 1'b0, '0);
      add_row(16'hFFFF, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h7FFF, 1'b0, 1'b0, '0);
      add_row(16'h8000, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'hFFFF, 1'b0, 1'b0, '0);
      add_row(16'h8000, 1'b0, 1'b0, '0);
      add_row(16'h7FFF, 1'b1, 1'b1,
              {32'h007FFF00, 32'hFF800000, 32'hFF800000, 32'h007FFF00, 1'b1});
      add_row(16'hFFFF, 1'b1, 1'b0, '0);
      add_row(16'h5555, 1'b0, 1'b0, '0);
      add_row(16'hAAAA, 1'b0, 1'b0, '0);
      add_row(16'h1234, 1'b0, 1'b0, '0);
      add_row(16'h4321, 1'b1, 1'b0, '0);
      add_row(16'hFFFD, 1'b1, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h0001, 1'b0, 1'b0, '0);
      add_row(16'h0002, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h0003, 1'b0, 1'b0, '0);
      add_row(16'h0004, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'h0000, 1'b0, 1'b0, '0);
      add_row(16'hFFFF, 1'b0, 1'b0, '0);
      add_row(16'hFFFE, 1'b0, 1'b0, '0);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].word);
         n = edge_step(dir_rows[i].word);
         if (dir_rows[i].typed) begin
            if (dir_rows[i].one_seg)
               segs_due.push_back(dir_rows[i].seg);
         end else begin
            for (int k = 0; k < n; k++)
               segs_due.push_back(step_segs[k]);
         end
      end
      settle();

      // Random phases; each starts on a new scale, often with a primitive still open.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: phase_scale = 16'hFFFF;
            1: phase_scale = 16'h0000;
            2: phase_scale = 16'h0001;
            5: phase_scale = sfwe_pkg::SCALE_RESET;
            default: phase_scale = 16'($urandom);
         endcase
         set_scale(phase_scale);
         calm = (ph == 3);
         if (ph == 2)
            hold_asks++;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            w = next_cmd_word();
            send_word(w);
            queue_step(w);
         end
         settle();
      end
      calm = 1'b0;

      // Finish the open primitive, then the most negative count opens a saturated fan.
      while (gen_left != 0) begin
         w = next_cmd_word();
         send_word(w);
         queue_step(w);
      end
      send_word(16'h8000);
      queue_step(16'h8000);
      gen_left = SAT_VERTS;
      gen_pos = 0;
      while (gen_left != 0) begin
         w = next_cmd_word();
         send_word(w);
         queue_step(w);
      end
      settle();

      mismatches += segs_due.size();
      $display("%0d command words sent, %0d segments checked, %0d failures", words_sent,
               segs_checked, mismatches);
      $display("scales 0, 1, 256, 65535 and random; strips, fans, one-vertex and empty lists");
      if (mismatches == 0)
         $display("tb_strip_fan_wireframe_edge_gen: done, clean");
      else
         $display("tb_strip_fan_wireframe_edge_gen: done, errors");
      $finish;
   end

endmodule
